@@ rtl/mkd_pkg.sv @@
// mkd_pkg: command codes, result record, character constants and the code table
// of the keyed Morse decoder
// no dependencies
package mkd_pkg;

	typedef enum logic [2:0] {
		CMD_RELEASE = 3'd0,
		CMD_LETTER  = 3'd1,
		CMD_WORD    = 3'd2,
		CMD_BACK    = 3'd3,
		CMD_TICK    = 3'd4,
		CMD_FLUSH   = 3'd5
	} cmd_e;

	typedef enum logic [0:0] {
		KIND_APPEND = 1'b0,
		KIND_DELETE = 1'b1
	} kind_e;

	typedef struct packed {
		logic       kind;
		logic [6:0] char_code;
		logic       last;
	} result_t;

	// up to two results written into the output queue per transaction
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	localparam int unsigned RES_FIFO_DEPTH = 4;

	localparam logic [15:0] DASH_THRESHOLD_RESET = 16'd300;
	localparam logic [15:0] LETTER_GAP_RESET     = 16'd1500;
	localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

	localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
	localparam logic [6:0] CHAR_SPACE   = 7'h20;
	localparam logic [6:0] CHAR_NONE    = 7'h00;

	localparam int unsigned CODE_COUNT   = 36;
	localparam int unsigned CODE_MAX_LEN = 5;

	// bit i set when element i is a dash
	localparam logic [4:0] CODE_BITS [CODE_COUNT] = '{
		5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0,
		5'd14, 5'd5, 5'd2, 5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2,
		5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
		5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7,
		5'd15
	};

	localparam logic [2:0] CODE_LEN [CODE_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
		3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5
	};

	localparam logic [6:0] CODE_CHAR [CODE_COUNT] = '{
		7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
		7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
		7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39
	};

	// pattern bits above len are always zero, so a full compare is enough
	function automatic logic [6:0] code_lookup(logic [4:0] bits, logic [2:0] len);
		logic [6:0] ch;
		ch = CHAR_UNKNOWN;
		for (int i = 0; i < CODE_COUNT; i++) begin
			if (CODE_BITS[i] == bits && CODE_LEN[i] == len)
				ch = CODE_CHAR[i];
		end
		return ch;
	endfunction

endpackage

@@ rtl/mkd_if.sv @@
// mkd_if: valid/ready channel interfaces of the keyed Morse decoder
// command channel in, result channel out; no dependencies
interface mkd_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [15:0] held_ms;

	modport source(output valid, command, held_ms, input ready);
	modport sink(input valid, command, held_ms, output ready);
endinterface

interface mkd_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [6:0] char_code;
	logic       last;

	modport source(output valid, kind, char_code, last, input ready);
	modport sink(input valid, kind, char_code, last, output ready);
endinterface

@@ rtl/mkd_res_fifo.sv @@
// mkd_res_fifo: small result queue, takes up to two results per cycle and
// drives one per transaction on the result channel
// depends on mkd_pkg and mkd_if
module mkd_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  mkd_pkg::push_t push,
	output logic          room,
	mkd_res_if.source     res
);
	import mkd_pkg::*;

	localparam int unsigned AW = $clog2(RES_FIFO_DEPTH);

	result_t        mem [RES_FIFO_DEPTH];
	logic [AW-1:0]  rd_q;
	logic [AW-1:0]  wr_q;
	logic [AW:0]    cnt_q;
	logic           pop;
	result_t        head;

	assign head          = mem[rd_q];
	assign res.valid     = cnt_q != '0;
	assign res.kind      = head.kind;
	assign res.char_code = head.char_code;
	assign res.last      = head.last;
	assign pop           = res.valid && res.ready;
	// room for a two-result write
	assign room          = cnt_q <= (AW+1)'(RES_FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.count == 2'd2)
			mem[wr_q + AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			rd_q  <= rd_q + AW'(pop);
			wr_q  <= wr_q + AW'(push.count);
			cnt_q <= cnt_q + (AW+1)'(push.count) - (AW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(RES_FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> cnt_q <= (AW+1)'(RES_FIFO_DEPTH - 2))
		else $error("results written without room");
endmodule

@@ rtl/morse_keyed_decoder_top.sv @@
// morse_keyed_decoder_top: keyed Morse decoder, builds letters from key events
// and emits decoded characters and deletes
// depends on mkd_pkg, mkd_if and mkd_res_fifo
//
//  channel   dir  payload                      transaction
//  cmd       in   command[2:0], held_ms[15:0]  valid & ready
//  res       out  kind, char_code[6:0], last   valid & ready
//  cfg       in   cfg_index, cfg_wdata[15:0]   cfg_we
//
// one command per cycle while the queue has room: input register, then decode/update logic
// writing the result queue; a result is valid on res once the queue has registered it
// a command causing two results (word space) sends them as two transactions on the result channel
// cmd.ready drops only while a command waits and the 4-entry queue lacks room for two results
// reset clears pattern, timer, text count and restores register defaults
module morse_keyed_decoder_top #(
	parameter int unsigned MAX_ELEMENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	mkd_cmd_if.sink     cmd,
	mkd_res_if.source   res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import mkd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

	logic                    valid_s1;
	logic [2:0]              cmd_s1;
	logic [15:0]             held_s1;

	logic [15:0]             thr_q;
	logic [15:0]             gap_ms_q;
	logic [MAX_ELEMENTS-1:0] pattern_q, pattern_d;
	logic [CW-1:0]           count_q, count_d;
	logic [15:0]             gap_q, gap_d;
	logic                    armed_q, armed_d;
	logic [15:0]             text_q, text_d;

	logic                    room;
	logic                    go;
	push_t                   push;
	logic [6:0]              dec_char;
	logic                    pend;
	logic [15:0]             text_inc1, text_inc2, gap_inc;
	logic [CW-1:0]           count_dec;

	assign go        = valid_s1 && room;
	assign cmd.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.ready)
			valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1  <= cmd.command;
			held_s1 <= cmd.held_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= DASH_THRESHOLD_RESET;
			gap_ms_q <= LETTER_GAP_RESET;
		end else if (cfg_we) begin
			if (cfg_index)
				gap_ms_q <= cfg_wdata;
			else
				thr_q <= cfg_wdata;
		end
	end

	assign pend      = count_q != '0;
	assign count_dec = count_q - CW'(1);
	assign dec_char  = (count_q > CW'(CODE_MAX_LEN)) ? CHAR_UNKNOWN
		: code_lookup(pattern_q[4:0], count_q[2:0]);
	assign text_inc1 = (text_q == COUNT_MAX) ? text_q : text_q + 16'd1;
	assign text_inc2 = (text_inc1 == COUNT_MAX) ? text_inc1 : text_inc1 + 16'd1;
	assign gap_inc   = (gap_q == COUNT_MAX) ? gap_q : gap_q + 16'd1;

	always_comb begin
		pattern_d  = pattern_q;
		count_d    = count_q;
		gap_d      = gap_q;
		armed_d    = armed_q;
		text_d     = text_q;
		push.count = 2'd0;
		push.r0    = '{kind: KIND_APPEND, char_code: dec_char, last: 1'b1};
		push.r1    = '{kind: KIND_APPEND, char_code: CHAR_SPACE, last: 1'b1};
		if (go) begin
			unique case (cmd_s1)
				CMD_RELEASE: begin
					if (count_q < CW'(MAX_ELEMENTS)) begin
						if (held_s1 >= thr_q)
							pattern_d = pattern_q | (MAX_ELEMENTS'(1) << count_q);
						count_d = count_q + CW'(1);
					end
					gap_d   = '0;
					armed_d = 1'b1;
				end
				CMD_LETTER, CMD_FLUSH: begin
					if (pend) begin
						push.count = 2'd1;
						pattern_d  = '0;
						count_d    = '0;
						text_d     = text_inc1;
					end
				end
				CMD_WORD: begin
					pattern_d = '0;
					count_d   = '0;
					if (pend) begin
						push.count        = 2'd2;
						push.r0.last      = 1'b0;
						text_d            = text_inc2;
					end else begin
						push.count        = 2'd1;
						push.r0.char_code = CHAR_SPACE;
						text_d            = text_inc1;
					end
				end
				CMD_BACK: begin
					if (pend) begin
						count_d   = count_dec;
						pattern_d = pattern_q & ~(MAX_ELEMENTS'(1) << count_dec);
					end else if (text_q != '0) begin
						push.count        = 2'd1;
						push.r0.kind      = KIND_DELETE;
						push.r0.char_code = CHAR_NONE;
						text_d            = text_q - 16'd1;
					end
				end
				CMD_TICK: begin
					if (armed_q) begin
						gap_d = gap_inc;
						// idle timeout decodes the pending letter once
						if (pend && gap_inc > gap_ms_q) begin
							push.count = 2'd1;
							pattern_d  = '0;
							count_d    = '0;
							text_d     = text_inc1;
							armed_d    = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			count_q   <= '0;
			gap_q     <= '0;
			armed_q   <= 1'b0;
			text_q    <= '0;
		end else begin
			pattern_q <= pattern_d;
			count_q   <= count_d;
			gap_q     <= gap_d;
			armed_q   <= armed_d;
			text_q    <= text_d;
		end
	end

	mkd_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.res    (res)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("element count beyond limit");

	a_pattern_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pattern_q >> count_q) == '0)
		else $error("stale dash bits above pending elements");

	a_timeout_emits: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(armed_q) |-> $past(push.count) == 2'd1)
		else $error("timer disarmed without a decoded character");
endmodule

@@ tb/mkd_tb_pkg.sv @@
`timescale 1ns / 1ps
// mkd_tb_pkg: register indexes and spare command codes shared by the decoder testbench
// no dependencies
package mkd_tb_pkg;

	localparam logic REG_DASH_THRESHOLD = 1'b0;
	localparam logic REG_LETTER_GAP     = 1'b1;

	// command codes the block must ignore
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

endpackage

@@ tb/mkd_checker.sv @@
`timescale 1ns / 1ps
// mkd_checker: watches the command, result and register ports of the keyed Morse decoder,
// predicts the text edits each command causes and compares them with the result channel
// depends on mkd_pkg, mkd_tb_pkg and mkd_if
module mkd_checker #(
	parameter int unsigned MAX_ELEMENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	mkd_cmd_if          cmd,
	mkd_res_if          res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          outstanding
);
	import mkd_pkg::*;
	import mkd_tb_pkg::*;

	typedef struct packed {
		kind_e      kind;
		logic [6:0] char_code;
		logic       last;
	} text_edit_t;

	logic [15:0]             dash_thr;
	logic [15:0]             letter_gap;
	logic [MAX_ELEMENTS-1:0] pat;
	int unsigned             elem_cnt;
	logic [15:0]             gap_elapsed;
	logic                    armed;
	logic [15:0]             text_len;

	text_edit_t text_edits_due [$];
	text_edit_t step_out [2];
	int         step_n;

	function automatic logic [6:0] match_symbol(input logic [MAX_ELEMENTS-1:0] bits,
		input int unsigned count);
		string codes;
		string letters;
		string sym;
		string tok;
		byte   ch;
		int    idx;
		int    j;
		int    p;
		codes = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- .--. --.- .-. ",
			"... - ..- ...- .-- -..- -.-- --.. ----- .---- ..--- ...-- ....- ..... -.... ",
			"--... ---.. ----. "};
		letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
		sym = "";
		tok = "";
		idx = 0;
		for (j = 0; j < count; j++) begin
			if (bits[j])
				sym = {sym, "-"};
			else
				sym = {sym, "."};
		end
		for (p = 0; p < codes.len(); p++) begin
			if (codes[p] == " ") begin
				if (tok == sym) begin
					ch = letters[idx];
					return ch[6:0];
				end
				idx++;
				tok = "";
			end else begin
				tok = {tok, codes.substr(p, p)};
			end
		end
		return CHAR_UNKNOWN;
	endfunction

	task append_text(input logic [6:0] ch);
		step_out[step_n] = {KIND_APPEND, ch, 1'b0};
		step_n++;
		if (text_len != 16'hFFFF)
			text_len++;
	endtask

	task decode_pending;
		if (elem_cnt != 0) begin
			append_text(match_symbol(pat, elem_cnt));
			pat = '0;
			elem_cnt = 0;
		end
	endtask

	task apply_key_command(input logic [2:0] code, input logic [15:0] held);
		step_n = 0;
		case (code)
			CMD_RELEASE: begin
				if (elem_cnt < MAX_ELEMENTS) begin
					if (held >= dash_thr)
						pat[elem_cnt] = 1'b1;
					elem_cnt++;
				end
				gap_elapsed = '0;
				armed = 1'b1;
			end
			CMD_LETTER, CMD_FLUSH: decode_pending();
			CMD_WORD: begin
				decode_pending();
				append_text(CHAR_SPACE);
			end
			CMD_BACK: begin
				if (elem_cnt > 0) begin
					elem_cnt--;
					pat[elem_cnt] = 1'b0;
				end else if (text_len != 0) begin
					step_out[step_n] = {KIND_DELETE, CHAR_NONE, 1'b0};
					step_n++;
					text_len--;
				end
			end
			CMD_TICK: begin
				if (armed) begin
					if (gap_elapsed != 16'hFFFF)
						gap_elapsed++;
					if (elem_cnt > 0 && gap_elapsed > letter_gap) begin
						decode_pending();
						armed = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (step_n > 0)
			step_out[step_n-1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			text_edits_due.push_back(step_out[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		text_edit_t got;
		text_edit_t want;
		if (!arst_n) begin
			dash_thr = DASH_THRESHOLD_RESET;
			letter_gap = LETTER_GAP_RESET;
			pat = '0;
			elem_cnt = 0;
			gap_elapsed = '0;
			armed = 1'b0;
			text_len = '0;
			text_edits_due.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DASH_THRESHOLD)
					dash_thr = cfg_wdata;
				else
					letter_gap = cfg_wdata;
			end
			if (res.valid && res.ready) begin
				got = {res.kind, res.char_code, res.last};
				if (text_edits_due.size() == 0) begin
					errors++;
					$display("%0t: result with none due, expected nothing, actual kind %0d char %h last %0d",
						$time, got.kind, got.char_code, got.last);
				end else begin
					want = text_edits_due.pop_front();
					if (got.kind != want.kind) begin
						errors++;
						$display("%0t: kind mismatch, expected %0d, actual %0d",
							$time, want.kind, got.kind);
					end
					if (got.char_code != want.char_code) begin
						errors++;
						$display("%0t: char_code mismatch, expected %h, actual %h",
							$time, want.char_code, got.char_code);
					end
					if (got.last != want.last) begin
						errors++;
						$display("%0t: last mismatch, expected %0d, actual %0d",
							$time, want.last, got.last);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				apply_key_command(cmd.command, cmd.held_ms);
			outstanding <= text_edits_due.size();
		end
	end

endmodule

@@ tb/tb_morse_keyed_decoder_top.sv @@
`timescale 1ns / 1ps
// tb_morse_keyed_decoder_top: stimulus and verdict for the keyed Morse decoder
// depends on mkd_pkg, mkd_tb_pkg, mkd_if, mkd_checker and morse_keyed_decoder_top
module tb_morse_keyed_decoder_top;
	import mkd_pkg::*;
	import mkd_tb_pkg::*;

	localparam int unsigned MAX_ELEMENTS = 8;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	int mismatches;
	int outstanding;
	int items_sent;
	int cycles;
	bit tx_gaps;
	bit rx_gaps;
	bit hold_off_req;

	// stimulus-side copy of the registers, used to aim hold times and tick runs
	logic [15:0] dash_thr;
	logic [15:0] letter_gap;

	mkd_cmd_if cmd_ch();
	mkd_res_if res_ch();

	morse_keyed_decoder_top #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	mkd_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_morse_keyed_decoder_top: done, errors");
		$finish;
	end

	function automatic logic [15:0] rand16(input int unsigned lo, input int unsigned hi);
		logic [31:0] r;
		r = $urandom_range(lo, hi);
		return r[15:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(12, 45);
	endfunction

	// hold times clustered around the dash threshold
	function automatic logic [15:0] pick_hold();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return dash_thr;
			1: return (dash_thr == 0) ? 16'd0 : dash_thr - 16'd1;
			2: return 16'd0;
			3: return 16'hFFFF;
			4, 5, 6: return (dash_thr == 0) ? rand16(0, 65535) : rand16(0, dash_thr - 1);
			default: return rand16(dash_thr, 65535);
		endcase
	endfunction

	// receiver: random ready, with one long hold-off on request
	initial begin : receiver
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!rx_gaps || $urandom_range(0, 99) < 60) begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				res_ch.ready <= 1'b0;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(15, 50)) @(posedge clk);
				else
					repeat ($urandom_range(1, 3)) @(posedge clk);
			end
		end
	end

	task send_item(input logic [2:0] code, input logic [15:0] held);
		int g;
		g = tx_gaps ? pick_gap() : 0;
		if (g > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= code;
		cmd_ch.held_ms <= held;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task send_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_item(CMD_TICK, rand16(0, 65535));
	endtask

	// wait until every result is out and the pipe holds nothing that causes none
	task settle;
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(input logic idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_DASH_THRESHOLD)
			dash_thr = value;
		else
			letter_gap = value;
	endtask

	task configure(input logic [15:0] thr, input logic [15:0] gap);
		settle();
		write_reg(REG_DASH_THRESHOLD, thr);
		write_reg(REG_LETTER_GAP, gap);
	endtask

	task send_letter;
		int k;
		int r;
		k = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5)
			: $urandom_range(6, MAX_ELEMENTS + 2);
		for (int e = 0; e < k; e++) begin
			send_item(CMD_RELEASE, pick_hold());
			r = $urandom_range(0, 99);
			if (r < 15)
				send_ticks($urandom_range(1, 4));
			else if (r < 20)
				send_item(CMD_BACK, rand16(0, 65535));
		end
		r = $urandom_range(0, 99);
		if (r < 35) begin
			send_item(CMD_LETTER, rand16(0, 65535));
		end else if (r < 60) begin
			send_item(CMD_WORD, rand16(0, 65535));
		end else if (r < 70) begin
			send_item(CMD_FLUSH, rand16(0, 65535));
		end else if (r < 85) begin
			if (letter_gap <= 40)
				send_ticks(letter_gap + 1 + $urandom_range(0, 2));
			else
				send_item(CMD_LETTER, rand16(0, 65535));
		end else if (r < 95) begin
			send_item(CMD_BACK, rand16(0, 65535));
			send_item(CMD_LETTER, rand16(0, 65535));
		end
		// otherwise the next letter runs on into this one
	endtask

	task random_phase(input int n);
		int start;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(0, 99) < 75)
				send_letter();
			else
				send_item(3'($urandom_range(0, 7)), rand16(0, 65535));
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_TICK;
		cmd_ch.held_ms <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DASH_THRESHOLD;
		cfg_wdata <= '0;
		dash_thr = DASH_THRESHOLD_RESET;
		letter_gap = LETTER_GAP_RESET;
		items_sent = 0;
		hold_off_req = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, threshold edges, long pattern, spare codes
		send_item(CMD_BACK, 16'd0);
		send_item(CMD_LETTER, 16'd0);
		send_item(CMD_TICK, 16'd0);
		send_item(CMD_WORD, 16'hFFFF);
		send_item(CMD_BACK, 16'hFFFF);
		send_item(CMD_RELEASE, 16'd300);
		send_item(CMD_RELEASE, 16'hFFFF);
		send_item(CMD_LETTER, 16'd0);
		send_item(CMD_RELEASE, 16'd299);
		send_item(CMD_FLUSH, 16'd0);
		for (int i = 0; i < 6; i++)
			send_item(CMD_RELEASE, 16'd0);
		send_item(CMD_WORD, 16'd0);
		send_item(CMD_SPARE_A, 16'hFFFF);
		send_item(CMD_SPARE_B, 16'hFFFF);
		send_item(CMD_RELEASE, 16'd0);
		send_item(CMD_RELEASE, 16'd400);
		send_item(CMD_BACK, 16'd0);
		send_item(CMD_LETTER, 16'd0);

		configure(16'd0, 16'd0);
		random_phase(150);
		configure(16'd1, 16'd1);
		random_phase(150);
		configure(16'hFFFF, 16'd2);
		random_phase(150);

		// long receiver hold-off while commands keep coming
		configure(rand16(1, 2000), 16'd4);
		hold_off_req = 1'b1;
		random_phase(200);

		for (int p = 0; p < 6; p++) begin
			tx_gaps = (p % 3) != 2;
			rx_gaps = (p % 2) == 0;
			configure(rand16(1, 2000), rand16(1, 20));
			random_phase(120);
		end

		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		configure(DASH_THRESHOLD_RESET, 16'd12);
		random_phase(100);

		settle();
		if (mismatches == 0)
			$display("tb_morse_keyed_decoder_top: done, clean");
		else
			$display("tb_morse_keyed_decoder_top: done, errors");
		$finish;
	end

endmodule
